// ===== rtl/hdl_pkg.sv =====
// hdl_pkg: types and constants shared by the hex dump loader
// character classes, digit phase codes, result record
// no dependencies
package hdl_pkg;

  localparam int unsigned MEM_BYTES_DEF = 32 * 1024;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned ADDR_W  = 15;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned MARK_W  = 16;
  localparam int unsigned ACC_W   = 16;
  localparam int unsigned PHASE_W = 3;

  localparam logic [PHASE_W-1:0] PH_ADDR_LAST = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ADDR_DONE = 3'd4;
  localparam logic [PHASE_W-1:0] PH_HALF_BYTE = 3'd5;

  typedef enum logic [2:0] {
    CLS_NEWLINE,
    CLS_BLANK,
    CLS_SKIP,
    CLS_HEX,
    CLS_BAD
  } char_cls_t;

  typedef struct packed {
    char_cls_t  cls;
    logic [3:0] nibble;
  } char_info_t;

  typedef struct packed {
    logic              wr_valid;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              parse_error;
    logic [MARK_W-1:0] high_mark;
  } result_t;

endpackage

// ===== rtl/hdl_if.sv =====
// hdl_in_if, hdl_out_if: valid/ready channels of the hex dump loader
// depends on hdl_pkg for field widths
interface hdl_in_if;
  logic                     valid;
  logic                     ready;
  logic [hdl_pkg::CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface hdl_out_if;
  logic                       valid;
  logic                       ready;
  logic                       wr_valid;
  logic [hdl_pkg::ADDR_W-1:0] wr_addr;
  logic [hdl_pkg::DATA_W-1:0] wr_data;
  logic                       parse_error;
  logic [hdl_pkg::MARK_W-1:0] high_mark;

  modport source (output valid, output wr_valid, output wr_addr, output wr_data,
                  output parse_error, output high_mark, input ready);
  modport sink   (input valid, input wr_valid, input wr_addr, input wr_data,
                  input parse_error, input high_mark, output ready);
endinterface

// ===== rtl/hex_dump_loader.sv =====
// hex_dump_loader: turns hex dump text, one character per transaction,
// into byte store commands; depends on hdl_pkg, hdl_if, hdl_char_class
// and hdl_parse_core
//
// in_chan carries one ascii character per transaction; out_chan returns
// exactly one result per character: a store strobe with address and
// byte, the sticky parse error flag and the high-water mark (one past
// the highest address stored, zero once an error is seen).
// a character is held in an input register, then the parser updates its
// line state and loads the result register, so a result is shown from the
// result register after its character has passed the input register; a
// stall on the result side can hold it there. the parser update is a single
// level of logic per character, giving one transaction per cycle sustained,
// limited only by the result side taking results.
// when the receiver stalls, the result register holds and the input
// register fills; in_chan.ready then drops until the result is taken.
// synchronous reset clears parser state and empties both registers; the
// first character after reset starts a new line at address zero.
module hex_dump_loader #(
  parameter int unsigned MEM_BYTES = hdl_pkg::MEM_BYTES_DEF
) (
  input logic     clk,
  input logic     rst_n,
  hdl_in_if.sink  in_chan,
  hdl_out_if.source out_chan
);

  logic [hdl_pkg::CH_W-1:0] ch_r;
  logic                     in_valid_r;
  logic                     out_valid_r;
  logic                     step;
  hdl_pkg::char_info_t      info;
  hdl_pkg::result_t         res;

  assign step          = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      ch_r <= in_chan.ch;
    end
  end

  hdl_char_class u_class (
    .ch   (ch_r),
    .info (info)
  );

  hdl_parse_core #(
    .MEM_BYTES (MEM_BYTES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .info  (info),
    .res   (res)
  );

  assign out_chan.valid       = out_valid_r;
  assign out_chan.wr_valid    = res.wr_valid;
  assign out_chan.wr_addr     = res.wr_addr;
  assign out_chan.wr_data     = res.wr_data;
  assign out_chan.parse_error = res.parse_error;
  assign out_chan.high_mark   = res.high_mark;

endmodule

// ===== rtl/hdl_char_class.sv =====
// hdl_char_class: sorts one ascii character into a class and hex value
// depends on hdl_pkg
module hdl_char_class (
  input  logic [hdl_pkg::CH_W-1:0] ch,
  output hdl_pkg::char_info_t      info
);

  always_comb begin
    info.cls    = hdl_pkg::CLS_BAD;
    info.nibble = 4'd0;
    case (ch) inside
      8'h0A: begin
        info.cls = hdl_pkg::CLS_NEWLINE;
      end
      8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: begin
        info.cls = hdl_pkg::CLS_BLANK;
      end
      8'h3B, 8'h00: begin
        info.cls = hdl_pkg::CLS_SKIP;
      end
      [8'h30:8'h39]: begin
        info.cls    = hdl_pkg::CLS_HEX;
        info.nibble = ch[3:0];
      end
      [8'h41:8'h46], [8'h61:8'h66]: begin
        // letters a to f: low three bits 1..6 map to 10..15
        info.cls    = hdl_pkg::CLS_HEX;
        info.nibble = 4'(ch[2:0] + 3'd1) + 4'd8;
      end
      default: begin
        info.cls = hdl_pkg::CLS_BAD;
      end
    endcase
  end

endmodule

// ===== rtl/hdl_parse_core.sv =====
// hdl_parse_core: line parser state and result register
// depends on hdl_pkg; fed by hdl_char_class
module hdl_parse_core #(
  parameter int unsigned MEM_BYTES = hdl_pkg::MEM_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  hdl_pkg::char_info_t info,
  output hdl_pkg::result_t    res
);

  localparam logic [hdl_pkg::ACC_W:0] MEM_LIMIT = (hdl_pkg::ACC_W+1)'(MEM_BYTES);

  logic [hdl_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [hdl_pkg::ACC_W-1:0]   accum_r, accum_nxt;
  logic [hdl_pkg::ACC_W-1:0]   load_r, load_nxt;
  logic                        skip_r, skip_nxt;
  logic                        err_r, err_nxt;
  logic [hdl_pkg::MARK_W-1:0]  top_r, top_nxt;
  hdl_pkg::result_t            res_r, res_nxt;
  logic [hdl_pkg::ACC_W-1:0]   shifted;
  logic [hdl_pkg::ACC_W-1:0]   load_inc;

  assign shifted  = {accum_r[hdl_pkg::ACC_W-5:0], info.nibble};
  assign load_inc = load_r + 16'd1;

  always_comb begin
    phase_nxt       = phase_r;
    accum_nxt       = accum_r;
    load_nxt        = load_r;
    skip_nxt        = skip_r;
    err_nxt         = err_r;
    top_nxt         = top_r;
    res_nxt.wr_valid = 1'b0;
    res_nxt.wr_addr  = '0;
    res_nxt.wr_data  = '0;
    if (!err_r) begin
      if (info.cls == hdl_pkg::CLS_NEWLINE) begin
        phase_nxt = '0;
        accum_nxt = '0;
        load_nxt  = '0;
        skip_nxt  = 1'b0;
      end else if (!skip_r) begin
        case (info.cls)
          hdl_pkg::CLS_SKIP: begin
            skip_nxt = 1'b1;
          end
          hdl_pkg::CLS_BAD: begin
            err_nxt = 1'b1;
            top_nxt = '0;
          end
          hdl_pkg::CLS_HEX: begin
            accum_nxt = shifted;
            if (phase_r < hdl_pkg::PH_ADDR_LAST) begin
              phase_nxt = phase_r + 3'd1;
            end else if (phase_r == hdl_pkg::PH_ADDR_LAST) begin
              load_nxt  = shifted;
              accum_nxt = '0;
              phase_nxt = hdl_pkg::PH_ADDR_DONE;
            end else if ({1'b0, load_r} >= MEM_LIMIT) begin
              skip_nxt = 1'b1;
            end else if (phase_r == hdl_pkg::PH_ADDR_DONE) begin
              phase_nxt = hdl_pkg::PH_HALF_BYTE;
            end else begin
              res_nxt.wr_valid = 1'b1;
              res_nxt.wr_addr  = load_r[hdl_pkg::ADDR_W-1:0];
              res_nxt.wr_data  = shifted[hdl_pkg::DATA_W-1:0];
              accum_nxt        = '0;
              load_nxt         = load_inc;
              if (load_inc > top_r) begin
                top_nxt = load_inc;
              end
              phase_nxt = hdl_pkg::PH_ADDR_DONE;
            end
          end
          default: begin
            // blanks fall through untouched
          end
        endcase
      end
    end
    res_nxt.parse_error = err_nxt;
    res_nxt.high_mark   = err_nxt ? '0 : top_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      accum_r <= '0;
      load_r  <= '0;
      skip_r  <= 1'b0;
      err_r   <= 1'b0;
      top_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      load_r  <= load_nxt;
      skip_r  <= skip_nxt;
      err_r   <= err_nxt;
      top_r   <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== tb/hdl_result_checker.sv =====
// hdl_result_checker: watches both channels of the hex dump loader, predicts
// one result per character and compares it with the block's results
// depends on hdl_pkg and on the hdl_in_if / hdl_out_if interfaces
`timescale 1ns / 100ps

module hdl_result_checker
  import hdl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  hdl_in_if    in_chan,
  hdl_out_if   out_chan,
  output int   fail_count,
  output int   pending
);

  localparam int unsigned MEM_LIMIT = MEM_BYTES_DEF;

  localparam logic [CH_W-1:0] CH_NUL = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB = 8'h09;
  localparam logic [CH_W-1:0] CH_NL  = 8'h0A;
  localparam logic [CH_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CH_W-1:0] CH_FF  = 8'h0C;
  localparam logic [CH_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CH_W-1:0] CH_SP  = 8'h20;
  localparam logic [CH_W-1:0] CH_SEMI = ";";

  logic [PHASE_W-1:0] line_phase;
  logic [ACC_W-1:0]   nibble_acc;
  logic [15:0]        store_addr;
  logic               rest_skipped;
  logic               error_flag;
  logic [MARK_W-1:0]  water_mark;

  result_t expected_results[$];
  int      errors = 0;

  function automatic result_t predict_char(input logic [CH_W-1:0] c);
    result_t    r;
    char_cls_t  cls;
    logic [3:0] nib;
    r   = '0;
    nib = '0;
    if (c == CH_NL) begin
      cls = CLS_NEWLINE;
    end else if (c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR) begin
      cls = CLS_BLANK;
    end else if (c == CH_SEMI || c == CH_NUL) begin
      cls = CLS_SKIP;
    end else if (c >= "0" && c <= "9") begin
      cls = CLS_HEX;
      nib = 4'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      cls = CLS_HEX;
      nib = 4'(c - "A" + 8'd10);
    end else if (c >= "a" && c <= "f") begin
      cls = CLS_HEX;
      nib = 4'(c - "a" + 8'd10);
    end else begin
      cls = CLS_BAD;
    end

    if (!error_flag) begin
      if (cls == CLS_NEWLINE) begin
        line_phase   = '0;
        nibble_acc   = '0;
        store_addr   = '0;
        rest_skipped = 1'b0;
      end else if (cls != CLS_BLANK && !rest_skipped) begin
        case (cls)
          CLS_SKIP: begin
            rest_skipped = 1'b1;
          end
          CLS_BAD: begin
            error_flag = 1'b1;
            water_mark = '0;
          end
          default: begin
            nibble_acc = {nibble_acc[ACC_W-5:0], nib};
            if (line_phase < PH_ADDR_LAST) begin
              line_phase = line_phase + 3'd1;
            end else if (line_phase == PH_ADDR_LAST) begin
              store_addr = nibble_acc;
              nibble_acc = '0;
              line_phase = PH_ADDR_DONE;
            end else if (32'(store_addr) >= MEM_LIMIT) begin
              rest_skipped = 1'b1;
            end else if (line_phase == PH_ADDR_DONE) begin
              line_phase = PH_HALF_BYTE;
            end else begin
              r.wr_valid = 1'b1;
              r.wr_addr  = store_addr[ADDR_W-1:0];
              r.wr_data  = nibble_acc[DATA_W-1:0];
              nibble_acc = '0;
              store_addr = store_addr + 16'd1;
              if (store_addr > water_mark) water_mark = store_addr;
              line_phase = PH_ADDR_DONE;
            end
          end
        endcase
      end
    end

    r.parse_error = error_flag;
    r.high_mark   = error_flag ? '0 : water_mark;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    result_t seen;
    if (!rst_n) begin
      line_phase   = '0;
      nibble_acc   = '0;
      store_addr   = '0;
      rest_skipped = 1'b0;
      error_flag   = 1'b0;
      water_mark   = '0;
      expected_results.delete();
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expected_results.push_back(predict_char(in_chan.ch));
      end
      if (out_chan.valid && out_chan.ready) begin
        seen.wr_valid    = out_chan.wr_valid;
        seen.wr_addr     = out_chan.wr_addr;
        seen.wr_data     = out_chan.wr_data;
        seen.parse_error = out_chan.parse_error;
        seen.high_mark   = out_chan.high_mark;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %h", $time, seen);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("wr_valid", 16'(exp_r.wr_valid), 16'(seen.wr_valid));
          check_field("wr_addr", 16'(exp_r.wr_addr), 16'(seen.wr_addr));
          check_field("wr_data", 16'(exp_r.wr_data), 16'(seen.wr_data));
          check_field("parse_error", 16'(exp_r.parse_error), 16'(seen.parse_error));
          check_field("high_mark", exp_r.high_mark, seen.high_mark);
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus and verdict for the hex dump loader; drives directed and
// random dump text with idling on both sides, the checker does the comparing
// depends on hdl_pkg, hdl_if, hex_dump_loader and hdl_result_checker
`timescale 1ns / 100ps

module tb_top;
  import hdl_pkg::*;

  localparam int N_ITEMS        = 1850;
  localparam int QUIET_TAIL     = 200;
  localparam int HOLD_AT        = 400;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int TIMEOUT_CYCLES = 500_000;

  localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB  = 8'h09;
  localparam logic [CH_W-1:0] CH_NL   = 8'h0A;
  localparam logic [CH_W-1:0] CH_VT   = 8'h0B;
  localparam logic [CH_W-1:0] CH_FF   = 8'h0C;
  localparam logic [CH_W-1:0] CH_CR   = 8'h0D;
  localparam logic [CH_W-1:0] CH_SP   = 8'h20;
  localparam logic [CH_W-1:0] CH_SEMI = ";";

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   sent_count = 0;
  bit   quiet = 1'b0;

  hdl_in_if  in_if ();
  hdl_out_if out_if ();

  hex_dump_loader i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  hdl_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [CH_W-1:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  function automatic logic [CH_W-1:0] random_blank();
    case ($urandom_range(0, 4))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_VT;
      3: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] any_but_newline();
    logic [CH_W-1:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_NL) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic send_char(input logic [CH_W-1:0] c);
    int len;
    if (!quiet && ((sent_count / 128) % 3 != 2) && $urandom_range(0, 11) == 0) begin
      len = $urandom_range(1, 19);
      in_if.valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_count++;
  endtask

  // low ndigits nibbles of v, most significant first, blanks now and then
  task automatic send_hex(input logic [15:0] v, input int ndigits);
    for (int i = ndigits - 1; i >= 0; i--) begin
      if ($urandom_range(0, 9) == 0) send_char(random_blank());
      send_char(hex_char(v[i*4 +: 4]));
    end
  endtask

  // receiver: random stall bursts, one long hold-off so the block backs up
  initial begin
    int  n;
    int  cyc;
    bit  held;
    cyc  = 0;
    held = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sent_count >= HOLD_AT) begin
        held = 1'b1;
        repeat (LONG_HOLD) begin
          out_if.ready <= 1'b0;
          @(posedge clk);
          cyc++;
        end
      end else if (!quiet && ((cyc / 150) % 3 != 1) && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 19);
        repeat (n) begin
          out_if.ready <= 1'b0;
          @(posedge clk);
          cyc++;
        end
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
        cyc++;
      end
    end
  end

  initial begin
    string       directed;
    logic [15:0] addr;
    int          kind;
    int          sel;
    int          nbytes;
    int          tail;
    int          drain;
    in_if.valid <= 1'b0;
    in_if.ch    <= '0;
    rst_n       <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // top-of-memory writes, out of range, short address, odd nibble, comment
    directed = "7ffE Ab\tcD0\n01\n00003;G\n";
    foreach (directed[i]) send_char(directed[i]);
    send_char(CH_VT);
    send_char(CH_FF);
    send_char(CH_CR);
    send_char(CH_NUL);
    send_char("Z");
    send_char(CH_NL);

    while (sent_count < N_ITEMS) begin
      if (sent_count > N_ITEMS - QUIET_TAIL) quiet = 1'b1;
      kind = $urandom_range(0, 99);
      sel  = $urandom_range(0, 99);
      if (sel < 55)      addr = 16'($urandom_range(0, 255));
      else if (sel < 72) addr = 16'h7FF0 + 16'($urandom_range(0, 31));
      else if (sel < 84) addr = 16'($urandom_range(0, 16'h7FFF));
      else if (sel < 94) addr = 16'($urandom_range(0, 16'hFFFF));
      else               addr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      if (kind < 6) begin
        send_hex(addr, $urandom_range(0, 3));
      end else if (kind < 10) begin
        repeat ($urandom_range(0, 3)) send_char(random_blank());
      end else begin
        send_hex(addr, 4);
        nbytes = $urandom_range(0, 10);
        repeat (nbytes) begin
          if ($urandom_range(0, 3) == 0) send_char(random_blank());
          send_hex(16'($urandom_range(0, 255)), 2);
        end
        tail = $urandom_range(0, 9);
        case (tail)
          0: send_char(hex_char(4'($urandom_range(0, 15))));
          1, 2: begin
            send_char(tail == 1 ? CH_SEMI : CH_NUL);
            repeat ($urandom_range(0, 6)) send_char(any_but_newline());
          end
          3: send_char(random_blank());
          default: ;
        endcase
      end
      send_char(CH_NL);
    end

    // sticky error, then characters that must all be ignored
    send_char($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hFF)) :
                                     8'($urandom_range("g", "z")));
    repeat (24) send_char(8'($urandom_range(0, 255)));
    in_if.valid <= 1'b0;
    @(posedge clk);

    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
